[rtl/slid_pkg.sv]
// Shared types, constants and control/status structs for the sorted list core.
package slid_pkg;

    // Table geometry
    localparam int CAPACITY = 128;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int LINK_W   = $clog2(CAPACITY + 1);
    localparam int ID_W     = 31;
    localparam int GRADE_W  = 16;
    localparam int COUNT_W  = 8;

    // Null link: one past the last slot
    localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(CAPACITY);

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_DUP       = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    // Input item
    typedef struct packed {
        logic               mode;
        logic [ID_W-1:0]    student_id;
        logic [GRADE_W-1:0] grade;
    } in_item_t;

    // Result item
    typedef struct packed {
        logic [1:0]         status;
        logic [COUNT_W-1:0] entry_count;
        logic               head_valid;
        logic [ID_W-1:0]    head_id;
        logic [GRADE_W-1:0] head_grade;
    } out_item_t;

    // Table read address source
    typedef enum logic [1:0] {
        RA_SCAN = 2'd0,
        RA_HEAD = 2'd1,
        RA_LINK = 2'd2
    } rd_sel_t;

    // Link table writes
    typedef enum logic [2:0] {
        LW_NONE      = 3'd0,
        LW_FREE_HEAD = 3'd1,
        LW_FREE_NXT  = 3'd2,
        LW_CUR_FREE  = 3'd3,
        LW_PREV_NEXT = 3'd4
    } link_wr_t;

    // Head pointer updates
    typedef enum logic [1:0] {
        HW_NONE = 2'd0,
        HW_FREE = 2'd1,
        HW_LINK = 2'd2
    } head_wr_t;

    // List walk pointer updates
    typedef enum logic [2:0] {
        WK_NONE      = 3'd0,
        WK_INS_START = 3'd1,
        WK_INS_STEP  = 3'd2,
        WK_DEL_START = 3'd3,
        WK_DEL_STEP  = 3'd4
    } walk_op_t;

    // Controller to datapath
    typedef struct packed {
        logic     accept;
        rd_sel_t  rd_sel;
        logic     scan_run;
        logic     wr_entry;
        link_wr_t link_wr;
        head_wr_t head_wr;
        walk_op_t walk_op;
        logic     del_entry;
        logic     status_wr;
        status_t  status;
        logic     out_load;
    } ctl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic mode_del;
        logic full;
        logic head_null;
        logic count_zero;
        logic dup_hit;
        logic scan_done;
        logic link_null;
        logic new_gt;
        logic rd_le;
        logic id_eq;
        logic prev_null;
        logic out_busy;
    } dp_stat_t;

endpackage

[rtl/slid_ctrl.sv]
// Controller state machine for the sorted list core.
module slid_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  slid_pkg::dp_stat_t stat,
    output slid_pkg::ctl_cmd_t cmd
);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_START  = 11'b000_0000_0010,
        S_SCAN   = 11'b000_0000_0100,
        S_IWRITE = 11'b000_0000_1000,
        S_IHCMP  = 11'b000_0001_0000,
        S_IWALK  = 11'b000_0010_0000,
        S_ILINK1 = 11'b000_0100_0000,
        S_ILINK2 = 11'b000_1000_0000,
        S_DCMP   = 11'b001_0000_0000,
        S_FREAD  = 11'b010_0000_0000,
        S_FOUT   = 11'b100_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_stall = (state_reg != S_IDLE);

    // Next state and datapath commands
    always_comb
    begin
        cmd           = '0;
        cmd.rd_sel    = slid_pkg::RA_HEAD;
        cmd.link_wr   = slid_pkg::LW_NONE;
        cmd.head_wr   = slid_pkg::HW_NONE;
        cmd.walk_op   = slid_pkg::WK_NONE;
        cmd.status    = slid_pkg::ST_OK;
        state_next    = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept    = 1'b1;
                    cmd.status_wr = 1'b1;
                    state_next    = S_START;
                end
            end
            S_START:
            begin
                if (stat.mode_del)
                begin
                    if (stat.head_null)
                    begin
                        cmd.status_wr = 1'b1;
                        cmd.status    = slid_pkg::ST_NOT_FOUND;
                        state_next    = S_FREAD;
                    end
                    else
                    begin
                        cmd.walk_op = slid_pkg::WK_DEL_START;
                        state_next  = S_DCMP;
                    end
                end
                else if (stat.full)
                begin
                    cmd.status_wr = 1'b1;
                    cmd.status    = slid_pkg::ST_FULL;
                    state_next    = S_FREAD;
                end
                else
                begin
                    cmd.scan_run = 1'b1;
                    cmd.rd_sel   = slid_pkg::RA_SCAN;
                    state_next   = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_run = 1'b1;
                cmd.rd_sel   = slid_pkg::RA_SCAN;
                if (stat.dup_hit)
                begin
                    cmd.status_wr = 1'b1;
                    cmd.status    = slid_pkg::ST_DUP;
                    state_next    = S_FREAD;
                end
                else if (stat.scan_done)
                begin
                    state_next = S_IWRITE;
                end
            end
            S_IWRITE:
            begin
                cmd.wr_entry = 1'b1;
                if (stat.head_null)
                begin
                    cmd.link_wr = slid_pkg::LW_FREE_HEAD;
                    cmd.head_wr = slid_pkg::HW_FREE;
                    state_next  = S_FREAD;
                end
                else
                begin
                    state_next = S_IHCMP;
                end
            end
            S_IHCMP:
            begin
                if (stat.new_gt)
                begin
                    cmd.link_wr = slid_pkg::LW_FREE_HEAD;
                    cmd.head_wr = slid_pkg::HW_FREE;
                    state_next  = S_FREAD;
                end
                else
                begin
                    cmd.walk_op = slid_pkg::WK_INS_START;
                    if (stat.link_null)
                    begin
                        state_next = S_ILINK1;
                    end
                    else
                    begin
                        cmd.rd_sel = slid_pkg::RA_LINK;
                        state_next = S_IWALK;
                    end
                end
            end
            S_IWALK:
            begin
                if (stat.rd_le)
                begin
                    state_next = S_ILINK1;
                end
                else
                begin
                    cmd.walk_op = slid_pkg::WK_INS_STEP;
                    if (stat.link_null)
                    begin
                        state_next = S_ILINK1;
                    end
                    else
                    begin
                        cmd.rd_sel = slid_pkg::RA_LINK;
                    end
                end
            end
            S_ILINK1:
            begin
                cmd.link_wr = slid_pkg::LW_FREE_NXT;
                state_next  = S_ILINK2;
            end
            S_ILINK2:
            begin
                cmd.link_wr = slid_pkg::LW_CUR_FREE;
                state_next  = S_FREAD;
            end
            S_DCMP:
            begin
                if (stat.id_eq)
                begin
                    cmd.del_entry = 1'b1;
                    if (stat.prev_null)
                    begin
                        cmd.head_wr = slid_pkg::HW_LINK;
                    end
                    else
                    begin
                        cmd.link_wr = slid_pkg::LW_PREV_NEXT;
                    end
                    state_next = S_FREAD;
                end
                else
                begin
                    cmd.walk_op = slid_pkg::WK_DEL_STEP;
                    if (stat.link_null)
                    begin
                        cmd.status_wr = 1'b1;
                        cmd.status    = slid_pkg::ST_NOT_FOUND;
                        state_next    = S_FREAD;
                    end
                    else
                    begin
                        cmd.rd_sel = slid_pkg::RA_LINK;
                    end
                end
            end
            S_FREAD:
            begin
                state_next = S_FOUT;
            end
            S_FOUT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/slid_dp.sv]
// Datapath of the sorted list core: entry tables, list pointers, scan and result register.
module slid_dp
(
    input  logic                clk,
    input  logic                rst_n,
    input  slid_pkg::in_item_t  in_data,
    input  slid_pkg::ctl_cmd_t  cmd,
    output slid_pkg::dp_stat_t  stat,
    output logic                out_valid,
    input  logic                out_stall,
    output slid_pkg::out_item_t out_data
);

    localparam int IDX_W   = slid_pkg::IDX_W;
    localparam int LINK_W  = slid_pkg::LINK_W;
    localparam int ID_W    = slid_pkg::ID_W;
    localparam int GRADE_W = slid_pkg::GRADE_W;
    localparam int CAP     = slid_pkg::CAPACITY;

    // Entry tables
    logic [ID_W-1:0]    id_mem    [CAP];
    logic [GRADE_W-1:0] grade_mem [CAP];
    logic [LINK_W-1:0]  link_mem  [CAP];

    logic [ID_W-1:0]    id_rd_reg;
    logic [GRADE_W-1:0] grade_rd_reg;
    logic [LINK_W-1:0]  link_rd_reg;

    // Held item and list state
    slid_pkg::in_item_t  item_reg;
    slid_pkg::status_t   status_reg,     status_next;
    logic [LINK_W-1:0]   count_reg,      count_next;
    logic [LINK_W-1:0]   head_reg,       head_next;
    logic [CAP-1:0]      used_reg,       used_next;
    logic [LINK_W-1:0]   scan_idx_reg,   scan_idx_next;
    logic                cmp_vld_reg,    cmp_vld_next;
    logic [IDX_W-1:0]    cmp_idx_reg,    cmp_idx_next;
    logic [IDX_W-1:0]    free_reg,       free_next;
    logic                free_found_reg, free_found_next;
    logic [LINK_W-1:0]   cur_reg,        cur_next;
    logic [LINK_W-1:0]   nxt_reg,        nxt_next;
    logic [LINK_W-1:0]   prev_reg,       prev_next;
    logic                out_valid_reg,  out_valid_next;
    slid_pkg::out_item_t out_reg;

    logic [IDX_W-1:0]  rd_addr;
    logic              link_we;
    logic [IDX_W-1:0]  link_waddr;
    logic [LINK_W-1:0] link_wdata;
    logic              scan_issue;
    logic              head_valid;

    // Read address select
    always_comb
    begin
        unique case (cmd.rd_sel)
            slid_pkg::RA_SCAN: rd_addr = scan_idx_reg[IDX_W-1:0];
            slid_pkg::RA_LINK: rd_addr = link_rd_reg[IDX_W-1:0];
            default:           rd_addr = head_reg[IDX_W-1:0];
        endcase
    end

    // Link write decode
    always_comb
    begin
        link_we    = 1'b1;
        link_waddr = free_reg;
        link_wdata = head_reg;
        unique case (cmd.link_wr)
            slid_pkg::LW_FREE_HEAD:
            begin
                link_waddr = free_reg;
                link_wdata = head_reg;
            end
            slid_pkg::LW_FREE_NXT:
            begin
                link_waddr = free_reg;
                link_wdata = nxt_reg;
            end
            slid_pkg::LW_CUR_FREE:
            begin
                link_waddr = cur_reg[IDX_W-1:0];
                link_wdata = LINK_W'(free_reg);
            end
            slid_pkg::LW_PREV_NEXT:
            begin
                link_waddr = prev_reg[IDX_W-1:0];
                link_wdata = link_rd_reg;
            end
            default:
            begin
                link_we = 1'b0;
            end
        endcase
    end

    // Tables: one write per table, registered read at one address
    always_ff @(posedge clk)
    begin
        if (cmd.wr_entry)
        begin
            id_mem[free_reg]    <= item_reg.student_id;
            grade_mem[free_reg] <= item_reg.grade;
        end
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        id_rd_reg    <= id_mem[rd_addr];
        grade_rd_reg <= grade_mem[rd_addr];
        link_rd_reg  <= link_mem[rd_addr];
    end

    assign scan_issue = cmd.scan_run && (scan_idx_reg < LINK_W'(CAP));

    // Control next values
    always_comb
    begin
        status_next     = status_reg;
        count_next      = count_reg;
        head_next       = head_reg;
        used_next       = used_reg;
        scan_idx_next   = scan_idx_reg;
        cmp_vld_next    = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        free_next       = free_reg;
        free_found_next = free_found_reg;
        cur_next        = cur_reg;
        nxt_next        = nxt_reg;
        prev_next       = prev_reg;

        if (cmd.status_wr)
        begin
            status_next = cmd.status;
        end

        // Duplicate scan and lowest free slot
        if (cmd.accept)
        begin
            scan_idx_next   = '0;
            free_found_next = 1'b0;
        end
        else if (scan_issue)
        begin
            scan_idx_next = scan_idx_reg + LINK_W'(1);
            cmp_vld_next  = 1'b1;
            cmp_idx_next  = scan_idx_reg[IDX_W-1:0];
            if (!used_reg[scan_idx_reg[IDX_W-1:0]] && !free_found_reg)
            begin
                free_next       = scan_idx_reg[IDX_W-1:0];
                free_found_next = 1'b1;
            end
        end

        // Entry allocate and free
        if (cmd.wr_entry)
        begin
            used_next[free_reg] = 1'b1;
            count_next          = count_reg + LINK_W'(1);
        end
        if (cmd.del_entry)
        begin
            used_next[cur_reg[IDX_W-1:0]] = 1'b0;
            count_next                    = count_reg - LINK_W'(1);
        end

        // Head pointer
        unique case (cmd.head_wr)
            slid_pkg::HW_FREE: head_next = LINK_W'(free_reg);
            slid_pkg::HW_LINK: head_next = link_rd_reg;
            default:           head_next = head_reg;
        endcase

        // Walk pointers
        unique case (cmd.walk_op)
            slid_pkg::WK_INS_START:
            begin
                cur_next = head_reg;
                nxt_next = link_rd_reg;
            end
            slid_pkg::WK_INS_STEP:
            begin
                cur_next = nxt_reg;
                nxt_next = link_rd_reg;
            end
            slid_pkg::WK_DEL_START:
            begin
                cur_next  = head_reg;
                prev_next = slid_pkg::NIL_LINK;
            end
            slid_pkg::WK_DEL_STEP:
            begin
                prev_next = cur_reg;
                cur_next  = link_rd_reg;
            end
            default:
            begin
                cur_next = cur_reg;
            end
        endcase
    end

    // Output register handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg     <= slid_pkg::ST_OK;
            count_reg      <= '0;
            head_reg       <= slid_pkg::NIL_LINK;
            used_reg       <= '0;
            scan_idx_reg   <= '0;
            cmp_vld_reg    <= 1'b0;
            cmp_idx_reg    <= '0;
            free_reg       <= '0;
            free_found_reg <= 1'b0;
            cur_reg        <= slid_pkg::NIL_LINK;
            nxt_reg        <= slid_pkg::NIL_LINK;
            prev_reg       <= slid_pkg::NIL_LINK;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            status_reg     <= status_next;
            count_reg      <= count_next;
            head_reg       <= head_next;
            used_reg       <= used_next;
            scan_idx_reg   <= scan_idx_next;
            cmp_vld_reg    <= cmp_vld_next;
            cmp_idx_reg    <= cmp_idx_next;
            free_reg       <= free_next;
            free_found_reg <= free_found_next;
            cur_reg        <= cur_next;
            nxt_reg        <= nxt_next;
            prev_reg       <= prev_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    assign head_valid = (head_reg != slid_pkg::NIL_LINK);

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            item_reg <= in_data;
        end
        if (cmd.out_load)
        begin
            out_reg.status      <= status_reg;
            out_reg.entry_count <= slid_pkg::COUNT_W'(count_reg);
            out_reg.head_valid  <= head_valid;
            out_reg.head_id     <= head_valid ? id_rd_reg : '0;
            out_reg.head_grade  <= head_valid ? grade_rd_reg : '0;
        end
    end

    // Status to controller
    always_comb
    begin
        stat.mode_del   = item_reg.mode;
        stat.full       = (count_reg >= LINK_W'(CAP));
        stat.head_null  = !head_valid;
        stat.count_zero = (count_reg == '0);
        stat.dup_hit    = cmp_vld_reg && used_reg[cmp_idx_reg]
                          && (id_rd_reg == item_reg.student_id);
        stat.scan_done  = cmp_vld_reg && (cmp_idx_reg == IDX_W'(CAP - 1));
        stat.link_null  = (link_rd_reg == slid_pkg::NIL_LINK);
        stat.new_gt     = (item_reg.grade > grade_rd_reg);
        stat.rd_le      = (grade_rd_reg <= item_reg.grade);
        stat.id_eq      = (id_rd_reg == item_reg.student_id);
        stat.prev_null  = (prev_reg == slid_pkg::NIL_LINK);
        stat.out_busy   = out_valid_reg && out_stall;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

[rtl/sorted_list_insert_delete_core.sv]
// Top level of the sorted list core: controller, datapath and checks.
//
// Holds up to CAPACITY (id, grade) entries linked in descending grade order and answers
// every item with one result: status, entry count and the head entry. The tables are
// single-read-port memories, so the scan and the list walk read one slot at a time. An
// insert runs a full duplicate scan over every slot, then walks the list up to the
// insertion point; an insert into a full table skips both. A delete walks the list until
// it finds the id or reaches the list end when the id is absent. The next item is taken
// once the current result is in the output register; that register holds it while the
// far side stalls. No clearing pass is needed after reset: slot occupancy lives in
// flip-flops cleared by reset.
module sorted_list_insert_delete_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  slid_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output slid_pkg::out_item_t out_data
);

    slid_pkg::ctl_cmd_t cmd;
    slid_pkg::dp_stat_t stat;

    slid_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    slid_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // Head pointer and entry count agree on emptiness
    a_head_count: assert property (@(posedge clk) disable iff (!rst_n)
        stat.head_null == stat.count_zero)
        else $error("head pointer and entry count disagree");

    // A result never overwrites one that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !stat.out_busy)
        else $error("result loaded over a stalled result");

    // An accepted item is never answered in the very next cycle
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> !cmd.out_load)
        else $error("result loaded right after accept");

endmodule

[dv/sorted_list_insert_delete_core_test.sv]
// Testbench for sorted_list_insert_delete_core: directed and random insert/delete traffic with a scoreboard.
`timescale 1ns / 100ps

module sorted_list_insert_delete_core_test;
    import slid_pkg::*;

    localparam logic               MODE_INSERT = 1'b0;
    localparam logic               MODE_DELETE = 1'b1;
    localparam int                 TOTAL_ITEMS = 1550;
    localparam int                 QUIET_ITEMS = 150;
    localparam int                 SETTLE_CYCLES = 300;
    localparam logic [ID_W-1:0]    ID_MAX = '1;
    localparam logic [GRADE_W-1:0] GRADE_MAX = '1;

    // Scoreboard: shadow copy of the sorted table and the queue of expected results
    class grade_list_board;
        logic [ID_W-1:0]    slot_id[CAPACITY];
        logic [GRADE_W-1:0] slot_grade[CAPACITY];
        int                 slot_next[CAPACITY];
        bit                 slot_busy[CAPACITY];
        int                 head_slot;
        int                 held;
        int                 peak_held;
        out_item_t          pending_results[$];
        int                 error_count;
        int                 results_checked;
        int                 status_tally[4];

        function new();
            head_slot = CAPACITY;
            held = 0;
            peak_held = 0;
            error_count = 0;
            results_checked = 0;
            foreach (slot_busy[i]) slot_busy[i] = 1'b0;
            foreach (status_tally[i]) status_tally[i] = 0;
        endfunction

        function int holds();
            return held;
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction

        // Any id currently in the table, starting the search at a random slot
        function logic [ID_W-1:0] random_held_id();
            int start;
            int idx;
            start = $urandom_range(0, CAPACITY - 1);
            for (int k = 0; k < CAPACITY; k++) begin
                idx = (start + k) % CAPACITY;
                if (slot_busy[idx]) return slot_id[idx];
            end
            return '0;
        endfunction

        // Insert: full check first, then duplicate scan, lowest free slot, sorted link-in
        function status_t insert_entry(logic [ID_W-1:0] id, logic [GRADE_W-1:0] grade);
            int slot;
            int cur;
            slot = CAPACITY;
            if (held >= CAPACITY) return ST_FULL;
            for (int i = 0; i < CAPACITY; i++)
                if (slot_busy[i] && slot_id[i] == id) return ST_DUP;
            for (int i = CAPACITY - 1; i >= 0; i--)
                if (!slot_busy[i]) slot = i;
            slot_id[slot] = id;
            slot_grade[slot] = grade;
            slot_busy[slot] = 1'b1;
            // only a strictly greater grade takes over the head
            if (head_slot == CAPACITY || grade > slot_grade[head_slot]) begin
                slot_next[slot] = head_slot;
                head_slot = slot;
            end
            else begin
                cur = head_slot;
                while (slot_next[cur] != CAPACITY && slot_grade[slot_next[cur]] > grade)
                    cur = slot_next[cur];
                slot_next[slot] = slot_next[cur];
                slot_next[cur] = slot;
            end
            held++;
            if (held > peak_held) peak_held = held;
            return ST_OK;
        endfunction

        // Delete: walk the list by id, unlink and free the slot
        function status_t delete_entry(logic [ID_W-1:0] id);
            int prev;
            int cur;
            prev = CAPACITY;
            cur = head_slot;
            while (cur != CAPACITY && slot_id[cur] != id) begin
                prev = cur;
                cur = slot_next[cur];
            end
            if (cur == CAPACITY) return ST_NOT_FOUND;
            if (prev == CAPACITY)
                head_slot = slot_next[cur];
            else
                slot_next[prev] = slot_next[cur];
            slot_busy[cur] = 1'b0;
            held--;
            return ST_OK;
        endfunction

        // Accepted input item: update the shadow table and queue the expected result
        function void note_item(in_item_t item);
            out_item_t want;
            status_t   st;
            if (item.mode == MODE_DELETE)
                st = delete_entry(item.student_id);
            else
                st = insert_entry(item.student_id, item.grade);
            want.status = st;
            want.entry_count = COUNT_W'(held);
            want.head_valid = (head_slot != CAPACITY);
            want.head_id = '0;
            want.head_grade = '0;
            if (head_slot != CAPACITY) begin
                want.head_id = slot_id[head_slot];
                want.head_grade = slot_grade[head_slot];
            end
            pending_results.push_back(want);
        endfunction

        task report_mismatch(string what);
            error_count++;
            if (error_count <= 40)
                $display("[%0t] MISMATCH result %0d: %s", $realtime, results_checked, what);
        endtask

        // Accepted result: compare field by field with the oldest expectation
        task check_result(out_item_t got);
            out_item_t want;
            results_checked++;
            if (pending_results.size() == 0) begin
                report_mismatch("result arrived with nothing expected");
                return;
            end
            want = pending_results.pop_front();
            status_tally[want.status]++;
            if (got.status !== want.status)
                report_mismatch($sformatf("status got %0d exp %0d", got.status, want.status));
            if (got.entry_count !== want.entry_count)
                report_mismatch($sformatf("entry_count got %0d exp %0d",
                                          got.entry_count, want.entry_count));
            if (got.head_valid !== want.head_valid)
                report_mismatch($sformatf("head_valid got %0b exp %0b",
                                          got.head_valid, want.head_valid));
            if (got.head_id !== want.head_id)
                report_mismatch($sformatf("head_id got %0h exp %0h", got.head_id, want.head_id));
            if (got.head_grade !== want.head_grade)
                report_mismatch($sformatf("head_grade got %0h exp %0h",
                                          got.head_grade, want.head_grade));
        endtask
    endclass

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_data;

    grade_list_board board = new();
    int  items_sent = 0;
    int  gap_pct = 0;
    int  stall_pct = 0;
    bit  quiet_tail = 1'b0;

    sorted_list_insert_delete_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always #4 clk = ~clk;

    // Run limit, far above the slowest legal run
    initial
    begin : watchdog
        #20_000_000;
        $display("sorted_list_insert_delete_core_test: done, errors");
        $finish;
    end

    // Result side: check accepted results, stall in random bursts
    initial
    begin : result_sink
        int burst_left;
        burst_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall) board.check_result(out_data);
            if (burst_left > 0)
                burst_left--;
            else if (!quiet_tail && stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
                burst_left = $urandom_range(1, 13);
            out_stall <= (burst_left > 0);
        end
    end

    // Drop valid and idle for a number of cycles
    task automatic hold_off(input int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Present one item, wait for it to be taken, then hand it to the scoreboard
    task automatic send_item(input logic mode, input logic [ID_W-1:0] id,
                             input logic [GRADE_W-1:0] grade);
        in_item_t item;
        item.mode = mode;
        item.student_id = id;
        item.grade = grade;
        quiet_tail = (items_sent >= TOTAL_ITEMS - QUIET_ITEMS);
        if (!quiet_tail && gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
            hold_off($urandom_range(1, 13));
        in_valid <= 1'b1;
        in_data <= item;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        board.note_item(item);
        items_sent++;
    endtask

    // Hold the sender until every expected result has come back
    task automatic wait_until_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (board.outstanding() != 0);
    endtask

    // Small ids collide often; full-width ones cover every bit
    function automatic logic [ID_W-1:0] pick_id();
        if ($urandom_range(0, 3) == 0) return ID_W'($urandom_range(0, 63));
        return ID_W'($urandom);
    endfunction

    // Grades from a coarse pool to force ties, plus extremes and full-width values
    function automatic logic [GRADE_W-1:0] pick_grade();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 1) ? GRADE_MAX : '0;
            1: return GRADE_W'($urandom_range(0, 7) * 9000);
            default: return GRADE_W'($urandom);
        endcase
    endfunction

    function automatic int idle_pct();
        case ($urandom_range(0, 3))
            0, 1: return 0;
            2: return 5;
            default: return 20;
        endcase
    endfunction

    // Insert until the table is full, then knock on the full table a few times
    task automatic fill_table();
        while (board.holds() < CAPACITY)
        begin
            if (board.holds() > 0 && $urandom_range(0, 9) == 0)
                send_item(MODE_INSERT, board.random_held_id(), pick_grade());
            else
                send_item(MODE_INSERT, pick_id(), pick_grade());
        end
        repeat ($urandom_range(2, 5))
        begin
            if ($urandom_range(0, 1) == 0)
                send_item(MODE_INSERT, board.random_held_id(), pick_grade());
            else
                send_item(MODE_INSERT, pick_id(), pick_grade());
        end
    endtask

    // Delete until empty, with the odd absent id
    task automatic drain_table();
        while (board.holds() > 0)
        begin
            if ($urandom_range(0, 9) == 0)
                send_item(MODE_DELETE, pick_id(), GRADE_W'($urandom));
            else
                send_item(MODE_DELETE, board.random_held_id(), GRADE_W'($urandom));
        end
    endtask

    // Mixed traffic: inserts, duplicates, deletes of present and absent ids
    task automatic mixed_burst(input int n);
        repeat (n)
        begin
            if ($urandom_range(0, 1) == 0) begin
                if (board.holds() > 0 && $urandom_range(0, 4) == 0)
                    send_item(MODE_INSERT, board.random_held_id(), pick_grade());
                else
                    send_item(MODE_INSERT, pick_id(), pick_grade());
            end
            else begin
                if (board.holds() > 0 && $urandom_range(0, 3) != 0)
                    send_item(MODE_DELETE, board.random_held_id(), GRADE_W'($urandom));
                else
                    send_item(MODE_DELETE, pick_id(), GRADE_W'($urandom));
            end
        end
    endtask

    // Directed: empty list, extremes, ties at head and tail, duplicates, all unlink positions
    task automatic run_directed();
        send_item(MODE_DELETE, ID_W'(5), GRADE_MAX);              // delete on empty list
        send_item(MODE_INSERT, '0, '0);                           // lowest id and grade
        send_item(MODE_INSERT, ID_MAX, GRADE_MAX);                // new head
        send_item(MODE_INSERT, ID_W'(100), GRADE_MAX);            // ties head, stays behind
        send_item(MODE_INSERT, ID_W'(101), '0);                   // ties tail, goes in front
        send_item(MODE_INSERT, '0, GRADE_W'(500));                // duplicate id
        send_item(MODE_INSERT, ID_MAX, '0);                       // duplicate id
        send_item(MODE_INSERT, ID_W'(200), 16'h8000);
        send_item(MODE_INSERT, ID_W'(201), 16'h8000);             // tie in the middle
        send_item(MODE_INSERT, 31'h2AAA_AAAA, 16'h5555);
        send_item(MODE_INSERT, 31'h5555_5555, 16'hAAAA);
        send_item(MODE_DELETE, ID_W'(999), '0);                   // absent id
        send_item(MODE_DELETE, ID_W'(200), 16'h1234);             // middle entry
        send_item(MODE_DELETE, ID_MAX, '0);                       // head entry
        send_item(MODE_DELETE, '0, '0);                           // tail entry
        send_item(MODE_DELETE, '0, '0);                           // already gone
        send_item(MODE_INSERT, ID_W'(300), GRADE_MAX);            // reuses a freed slot
        send_item(MODE_DELETE, ID_W'(100), '0);
        send_item(MODE_DELETE, ID_W'(201), '0);
        send_item(MODE_DELETE, ID_W'(101), '0);
        send_item(MODE_DELETE, 31'h2AAA_AAAA, '0);
        send_item(MODE_DELETE, 31'h5555_5555, GRADE_MAX);
        send_item(MODE_DELETE, ID_W'(300), '0);                   // list now empty
        send_item(MODE_DELETE, ID_W'(300), '0);
    endtask

    initial
    begin : stimulus
        int round;
        int settle;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_data <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gap_pct = 10;
        stall_pct = 10;
        run_directed();
        wait_until_drained();

        // Random rounds; the first one fills the table to capacity
        round = 0;
        while (items_sent < TOTAL_ITEMS)
        begin
            gap_pct = idle_pct();
            stall_pct = idle_pct();
            if (round == 0)
                fill_table();
            else begin
                case ($urandom_range(0, 3))
                    0: fill_table();
                    1: drain_table();
                    default: mixed_burst($urandom_range(20, 80));
                endcase
            end
            if ($urandom_range(0, 3) == 0) wait_until_drained();
            round++;
        end

        // Wind down: collect remaining results, then let the block settle
        in_valid <= 1'b0;
        settle = 0;
        do
        begin
            @(posedge clk);
            settle++;
        end
        while (board.outstanding() != 0 && settle < 20000);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (board.outstanding() != 0)
            board.report_mismatch($sformatf("%0d expected results never arrived",
                                            board.outstanding()));

        $display("summary: %0d items, %0d results; ok %0d, full %0d, duplicate %0d, absent %0d",
                 items_sent, board.results_checked, board.status_tally[ST_OK],
                 board.status_tally[ST_FULL], board.status_tally[ST_DUP],
                 board.status_tally[ST_NOT_FOUND]);
        $display("summary: table peaked at %0d of %0d entries, %0d mismatches",
                 board.peak_held, CAPACITY, board.error_count);
        if (board.error_count == 0)
            $display("sorted_list_insert_delete_core_test: done, clean");
        else
            $display("sorted_list_insert_delete_core_test: done, errors");
        $finish;
    end

endmodule
